@@ rtl/ipv4_source_nat_rewriter_assert.svh @@
// Assertion macros used by the port checker of the NAT rewriter.
// NSR_ASSERT expects clk and rst_n, NSR_ASSERT_ALWAYS clk, in the scope where it is used.
`ifndef IPV4_SOURCE_NAT_REWRITER_ASSERT_SVH
`define IPV4_SOURCE_NAT_REWRITER_ASSERT_SVH

// Property checked outside reset only
`define NSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define NSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/nsr_pkg.sv @@
`default_nettype none
package nsr_pkg;

  // Header geometry
  localparam int MAX_HEADER_BYTES = 60;
  localparam int MIN_HEADER_BYTES = 20;
  localparam int HDR_IDX_W        = $clog2(MAX_HEADER_BYTES + 1);

  // Fixed byte offsets inside the IPv4 header
  localparam logic [HDR_IDX_W-1:0] CKSUM_HI_POS = HDR_IDX_W'(10);
  localparam logic [HDR_IDX_W-1:0] CKSUM_LO_POS = HDR_IDX_W'(11);
  localparam logic [HDR_IDX_W-1:0] SRC0_POS     = HDR_IDX_W'(12);
  localparam logic [HDR_IDX_W-1:0] SRC1_POS     = HDR_IDX_W'(13);
  localparam logic [HDR_IDX_W-1:0] SRC2_POS     = HDR_IDX_W'(14);
  localparam logic [HDR_IDX_W-1:0] SRC3_POS     = HDR_IDX_W'(15);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // Command kinds
  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_PASS  = 2'd0;  // payload word, passes through
  localparam cmd_kind_t CMD_HDR   = 2'd1;  // complete header, rewrite and emit
  localparam cmd_kind_t CMD_SHORT = 2'd2;  // incomplete header, flush as stored

  typedef struct packed {
    cmd_kind_t            kind;
    logic [7:0]           data;
    logic                 last;
    logic [HDR_IDX_W-1:0] count;
    logic [15:0]          sum;
    logic [31:0]          nat;
  } cmd_t;

  // Header store write request
  typedef struct packed {
    logic                 we;
    logic [HDR_IDX_W-1:0] addr;
    logic [7:0]           data;
  } mem_wr_t;

  // 16-bit ones' complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/nsr_front.sv @@
`default_nettype none
module nsr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  logic [31:0]      nat_addr,
  input  logic             q_full,
  output logic             q_push,
  output nsr_pkg::cmd_t    q_cmd,
  output nsr_pkg::mem_wr_t mem_wr,
  input  logic             hdr_done
);
  import nsr_pkg::*;

  logic [HDR_IDX_W-1:0] pos_r, pos_nxt;
  logic [HDR_IDX_W-1:0] hlen_r, hlen_nxt;
  logic [15:0]          sum_r, sum_nxt;
  logic                 payload_r, payload_nxt;
  logic                 pending_r, pending_nxt;

  logic                 accept;
  logic [HDR_IDX_W-1:0] len_raw, len_new, hlen_cur, n_pos;
  logic [15:0]          word, sum_upd;
  logic                 complete;

  // Header words wait while the store is still being read out
  assign in_tready = !q_full && (payload_r || !pending_r);
  assign accept    = in_tvalid && in_tready;

  // Header length from IHL, clamped
  always_comb begin
    len_raw = {in_tdata[3:0], 2'b00};
    len_new = len_raw;
    if (len_raw < HDR_IDX_W'(MIN_HEADER_BYTES)) len_new = HDR_IDX_W'(MIN_HEADER_BYTES);
    if (len_raw > HDR_IDX_W'(MAX_HEADER_BYTES)) len_new = HDR_IDX_W'(MAX_HEADER_BYTES);
  end

  assign hlen_cur = (pos_r == '0) ? len_new : hlen_r;
  assign n_pos    = pos_r + HDR_IDX_W'(1);
  assign complete = (n_pos >= hlen_cur);

  // Running checksum; skip the checksum and source address fields
  assign word = pos_r[0] ? {8'h00, in_tdata} : {in_tdata, 8'h00};
  always_comb begin
    sum_upd = sum_r;
    if (pos_r < CKSUM_HI_POS || pos_r > SRC3_POS) sum_upd = fold_add(sum_r, word);
  end

  // Store header words as they arrive
  assign mem_wr.we   = accept && !payload_r;
  assign mem_wr.addr = pos_r;
  assign mem_wr.data = in_tdata;

  // Classify each word and issue commands
  always_comb begin
    pos_nxt     = pos_r;
    hlen_nxt    = hlen_r;
    sum_nxt     = sum_r;
    payload_nxt = payload_r;
    pending_nxt = pending_r;
    q_push      = 1'b0;
    q_cmd       = '0;
    if (hdr_done) pending_nxt = 1'b0;
    if (accept) begin
      q_cmd.data = in_tdata;
      q_cmd.last = in_tlast;
      if (payload_r) begin
        q_push     = 1'b1;
        q_cmd.kind = CMD_PASS;
        if (in_tlast) begin
          pos_nxt     = '0;
          hlen_nxt    = HDR_IDX_W'(MIN_HEADER_BYTES);
          sum_nxt     = '0;
          payload_nxt = 1'b0;
        end
      end else if (complete) begin
        q_push      = 1'b1;
        q_cmd.kind  = CMD_HDR;
        q_cmd.count = hlen_cur;
        q_cmd.sum   = sum_upd;
        q_cmd.nat   = nat_addr;
        pending_nxt = 1'b1;
        pos_nxt     = '0;
        sum_nxt     = '0;
        hlen_nxt    = in_tlast ? HDR_IDX_W'(MIN_HEADER_BYTES) : hlen_cur;
        payload_nxt = !in_tlast;
      end else if (in_tlast) begin
        q_push      = 1'b1;
        q_cmd.kind  = CMD_SHORT;
        q_cmd.count = n_pos;
        pending_nxt = 1'b1;
        pos_nxt     = '0;
        hlen_nxt    = HDR_IDX_W'(MIN_HEADER_BYTES);
        sum_nxt     = '0;
      end else begin
        pos_nxt  = n_pos;
        hlen_nxt = hlen_cur;
        sum_nxt  = sum_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hlen_r    <= HDR_IDX_W'(MIN_HEADER_BYTES);
      sum_r     <= '0;
      payload_r <= 1'b0;
      pending_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      hlen_r    <= hlen_nxt;
      sum_r     <= sum_nxt;
      payload_r <= payload_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nsr_cmd_fifo.sv @@
`default_nettype none
module nsr_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nsr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output nsr_pkg::cmd_t head_cmd,
  output logic          empty
);
  import nsr_pkg::*;

  cmd_t                  entries_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_PTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = entries_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + CMDQ_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + CMDQ_PTR_W'(1);
    end
    if (push && !pop) count_nxt = count_r + (CMDQ_PTR_W + 1)'(1);
    if (pop && !push) count_nxt = count_r - (CMDQ_PTR_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

@@ rtl/nsr_back.sv @@
`default_nettype none
module nsr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  nsr_pkg::mem_wr_t mem_wr,
  input  logic             q_empty,
  input  nsr_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             hdr_done,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);
  import nsr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CKSUM = 2'd1;
  localparam logic [1:0] ST_SEND  = 2'd2;

  // Header store
  logic [7:0] hdr_mem [MAX_HEADER_BYTES];
  logic [7:0] rdata_r;

  logic [1:0]           state_r, state_nxt;
  cmd_t                 cur_r, cur_nxt;
  logic [HDR_IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]          ck_r, ck_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_short_r, out_short_nxt;

  logic                 slot_free;
  logic                 rd_en;
  logic [HDR_IDX_W-1:0] rd_addr;
  logic                 is_final;
  logic [7:0]           hdr_byte;
  logic [15:0]          sum_hi;

  assign slot_free = !out_valid_r || out_tready;
  assign is_final  = (idx_r == cur_r.count - HDR_IDX_W'(1));
  assign sum_hi    = fold_add(cur_r.sum, cur_r.nat[31:16]);

  // Patch checksum and source address into a complete header
  always_comb begin
    hdr_byte = rdata_r;
    if (cur_r.kind == CMD_HDR) begin
      if (idx_r == CKSUM_HI_POS) hdr_byte = ck_r[15:8];
      if (idx_r == CKSUM_LO_POS) hdr_byte = ck_r[7:0];
      if (idx_r == SRC0_POS)     hdr_byte = cur_r.nat[31:24];
      if (idx_r == SRC1_POS)     hdr_byte = cur_r.nat[23:16];
      if (idx_r == SRC2_POS)     hdr_byte = cur_r.nat[15:8];
      if (idx_r == SRC3_POS)     hdr_byte = cur_r.nat[7:0];
    end
  end

  // Sequence commands into output words
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    ck_nxt        = ck_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_short_nxt = out_short_r;
    q_pop         = 1'b0;
    hdr_done      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind == CMD_PASS) begin
            if (slot_free) begin
              q_pop         = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = q_cmd.data;
              out_last_nxt  = q_cmd.last;
              out_short_nxt = 1'b0;
            end
          end else begin
            q_pop     = 1'b1;
            cur_nxt   = q_cmd;
            state_nxt = ST_CKSUM;
          end
        end
      end
      ST_CKSUM: begin
        ck_nxt    = ~fold_add(sum_hi, cur_r.nat[15:0]);
        idx_nxt   = '0;
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hdr_byte;
          out_short_nxt = (cur_r.kind == CMD_SHORT);
          out_last_nxt  = is_final && (cur_r.last || cur_r.kind == CMD_SHORT);
          if (is_final) begin
            hdr_done  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + HDR_IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + HDR_IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    idx_r       <= idx_nxt;
    ck_r        <= ck_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_short_r <= out_short_nxt;
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (mem_wr.we) hdr_mem[mem_wr.addr] <= mem_wr.data;
    if (rd_en)     rdata_r <= hdr_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_short_r;

endmodule
`default_nettype wire

@@ rtl/ipv4_source_nat_rewriter.sv @@
`default_nettype none
// Channel   Direction  Handshake          Contents
// in_       slave      tvalid / tready    tdata = data_byte, tlast = end_of_packet
// out_      master     tvalid / tready    tdata = out_byte, tlast = out_last,
//                                         tuser = header_short
// cfg_      APB slave  psel/penable/pready nat_address at byte address 0
//
// Payload words are queued, then registered at the output. Header words enter the
// header store one a cycle unless stalled; a complete header (or one cut short by
// the packet end) passes the queue, a checksum state and a registered store read,
// then leaves the store's single read port one word a cycle unless the output stalls.
// The next packet's header waits until the previous one is read out. A four-entry
// command queue lets input and output stall independently; reset is synchronous.
module ipv4_source_nat_rewriter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic        out_tuser,  // [0] header_short
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nsr_pkg::*;

  logic [31:0] nat_r;
  logic        cfg_wr;
  logic        q_full, q_empty, q_push, q_pop, hdr_done;
  cmd_t        push_cmd, head_cmd;
  mem_wr_t     mem_wr;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : nat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nat_r <= '0;
    end else if (cfg_wr) begin
      nat_r <= cfg_pwdata;
    end
  end

  nsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .nat_addr  (nat_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .mem_wr    (mem_wr),
    .hdr_done  (hdr_done)
  );

  nsr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  nsr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mem_wr     (mem_wr),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .hdr_done   (hdr_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

@@ rtl/nsr_port_checker.sv @@
`default_nettype none
`include "ipv4_source_nat_rewriter_assert.svh"
module nsr_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        out_tuser,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata
);

  // Stalled output word holds
  `NSR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "output word changed while stalled")

  // Reset empties the output register
  `NSR_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid, "output valid after reset")

  // A short-header flush runs without gaps to its last word
  `NSR_ASSERT(a_short_run, out_tvalid && out_tready && out_tuser && !out_tlast |=> out_tvalid && out_tuser, "short flush broken")

  // Written address reads back
  `NSR_ASSERT(a_cfg_rdback, cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2] |=> cfg_paddr[2] || (cfg_prdata == $past(cfg_pwdata)), "address register read back mismatch")

endmodule

bind ipv4_source_nat_rewriter nsr_port_checker u_port_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tlast   (out_tlast),
  .out_tuser   (out_tuser),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);
`default_nettype wire

@@ test/tb_ipv4_source_nat_rewriter.sv @@
`timescale 1ns / 1ps

// Register indexes on the configuration port
localparam int REG_NAT_ADDRESS = 0;
localparam int REG_SPARE       = 1;

typedef logic [7:0] byte_q_t [$];

// One word of the rewritten stream
typedef struct packed {
  logic [7:0] data;
  logic       last;
  logic       hdr_short;
} nat_word_t;

// Tracks the rewriter's header state and queues the words it must emit
class nat_rewrite_tracker;
  logic [31:0] nat_addr = '0;
  logic [7:0]  hdr_bytes [nsr_pkg::MAX_HEADER_BYTES];
  int          hdr_pos = 0;
  int          hdr_len = nsr_pkg::MIN_HEADER_BYTES;
  logic [15:0] partial_sum = '0;
  bit          in_payload = 0;
  nat_word_t   expected_words [$];
  int          words_in = 0;
  int          words_out = 0;
  int          full_headers = 0;
  int          short_flushes = 0;

  function void set_register(int index, logic [31:0] value);
    if (index == REG_NAT_ADDRESS) nat_addr = value;
  endfunction

  function void restart_packet();
    hdr_pos     = 0;
    hdr_len     = nsr_pkg::MIN_HEADER_BYTES;
    partial_sum = '0;
    in_payload  = 0;
  endfunction

  // 16-bit ones' complement add, carry wrapped back in
  function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = a + b;
    return s[15:0] + s[16];
  endfunction

  function void push_word(logic [7:0] data, logic last, logic hdr_short);
    nat_word_t w;
    w.data      = data;
    w.last      = last;
    w.hdr_short = hdr_short;
    expected_words.push_back(w);
  endfunction

  function void take_input_word(logic [7:0] b, logic eop);
    int          p;
    int          n;
    int          i;
    logic [15:0] sum;
    logic [15:0] ck;
    words_in++;
    // pass payload straight through
    if (in_payload) begin
      push_word(b, eop, 1'b0);
      if (eop) restart_packet();
      return;
    end
    p = (hdr_pos >= nsr_pkg::MAX_HEADER_BYTES) ? nsr_pkg::MAX_HEADER_BYTES - 1 : hdr_pos;
    hdr_bytes[p] = b;
    if (p == 0) begin
      hdr_len = int'(b[3:0]) * 4;
      if (hdr_len < nsr_pkg::MIN_HEADER_BYTES) hdr_len = nsr_pkg::MIN_HEADER_BYTES;
      if (hdr_len > nsr_pkg::MAX_HEADER_BYTES) hdr_len = nsr_pkg::MAX_HEADER_BYTES;
    end
    // skip checksum and source address bytes in the running sum
    if (p < int'(nsr_pkg::CKSUM_HI_POS) || p > int'(nsr_pkg::SRC3_POS))
      partial_sum = ones_add(partial_sum, ((p % 2) == 1) ? {8'h00, b} : {b, 8'h00});
    n = p + 1;
    hdr_pos = n % 64;

    if (n >= hdr_len) begin
      // rewrite source address and checksum, then emit whole header
      hdr_bytes[nsr_pkg::SRC0_POS] = nat_addr[31:24];
      hdr_bytes[nsr_pkg::SRC1_POS] = nat_addr[23:16];
      hdr_bytes[nsr_pkg::SRC2_POS] = nat_addr[15:8];
      hdr_bytes[nsr_pkg::SRC3_POS] = nat_addr[7:0];
      sum = ones_add(partial_sum, nat_addr[31:16]);
      sum = ones_add(sum, nat_addr[15:0]);
      ck  = ~sum;
      hdr_bytes[nsr_pkg::CKSUM_HI_POS] = ck[15:8];
      hdr_bytes[nsr_pkg::CKSUM_LO_POS] = ck[7:0];
      for (i = 0; i < hdr_len; i++)
        push_word(hdr_bytes[i], eop && (i == hdr_len - 1), 1'b0);
      full_headers++;
      if (eop) begin
        restart_packet();
      end else begin
        in_payload  = 1;
        hdr_pos     = 0;
        partial_sum = '0;
      end
    end else if (eop) begin
      // flush the partial header untouched
      for (i = 0; i < n; i++)
        push_word(hdr_bytes[i], i == n - 1, 1'b1);
      short_flushes++;
      restart_packet();
    end
  endfunction

  // Empty string when the word matches the oldest expectation
  function string match_output_word(logic [7:0] data, logic last, logic hdr_short);
    nat_word_t w;
    words_out++;
    if (expected_words.size() == 0)
      return $sformatf("output word %0d unexpected: data=%02h last=%0b short=%0b",
                       words_out, data, last, hdr_short);
    w = expected_words.pop_front();
    if (data !== w.data || last !== w.last || hdr_short !== w.hdr_short)
      return $sformatf("output word %0d: got data=%02h last=%0b short=%0b, want %02h %0b %0b",
                       words_out, data, last, hdr_short, w.data, w.last, w.hdr_short);
    return "";
  endfunction
endclass

module tb_ipv4_source_nat_rewriter;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 12;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int PHASE_WORDS      = 60;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tlast;
  logic        out_tuser;  // [0] header_short
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  nat_rewrite_tracker rewriter;
  int mismatch_count = 0;
  int packets_sent   = 0;
  int held_cycles    = 0;
  bit steady_flow    = 0;
  bit long_hold_req  = 0;
  bit hold_active    = 0;

  ipv4_source_nat_rewriter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Mostly short gaps, a few long ones; none while streaming steadily
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Setup then access cycle; register takes the value at the access edge
  task automatic cfg_write(input int index, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(index * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rewriter.set_register(index, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Offer words one by one; close marks the last word as end of packet
  task automatic send_bytes(input byte_q_t bytes, input bit close);
    int gap;
    int i;
    logic eop;
    for (i = 0; i < bytes.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      eop = close && (i == bytes.size() - 1);
      in_tvalid <= 1'b1;
      in_tdata  <= bytes[i];
      in_tlast  <= eop;
      do @(posedge clk); while (in_tready !== 1'b1);
      rewriter.take_input_word(bytes[i], eop);
    end
    if (close) packets_sent++;
  endtask

  // Drop valid, wait for expected words to drain, then let the block go quiet
  task automatic settle();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (rewriter.expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed datagrams; some cut short, some random noise
  function automatic byte_q_t random_packet();
    byte_q_t q;
    int kind;
    int ihl;
    int hlen;
    int total;
    int i;
    kind = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 15);
    hlen = (ihl * 4 < nsr_pkg::MIN_HEADER_BYTES) ? nsr_pkg::MIN_HEADER_BYTES : ihl * 4;
    if (kind < 72) begin
      if ($urandom_range(0, 5) == 0) total = hlen;
      else if ($urandom_range(0, 9) == 0) total = hlen + $urandom_range(30, 80);
      else total = hlen + $urandom_range(1, 12);
    end else if (kind < 92) begin
      total = $urandom_range(1, hlen - 1);
    end else begin
      total = $urandom_range(1, 90);
    end
    for (i = 0; i < total; i++) q.push_back(8'($urandom_range(0, 255)));
    if (kind < 92) begin
      if ($urandom_range(0, 7) == 0) q[0] = {4'($urandom_range(0, 15)), 4'(ihl)};
      else q[0] = {4'h4, 4'(ihl)};
    end
    return q;
  endfunction

  task automatic run_random_phase(input logic [31:0] addr, input bit pressure);
    byte_q_t pkt;
    int sent;
    cfg_write(REG_NAT_ADDRESS, addr);
    if (pressure) begin
      // receiver holds off while the sender streams without gaps
      steady_flow   = 1;
      long_hold_req = 1;
      while (!hold_active) @(posedge clk);
    end
    sent = 0;
    while (sent < PHASE_WORDS) begin
      pkt = random_packet();
      send_bytes(pkt, 1'b1);
      sent += pkt.size();
    end
    settle();
    steady_flow = 0;
  endtask

  // Receiver: random ready runs, one long hold on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_tready  <= 1'b0;
        hold_active = 1;
        for (held_cycles = 0; held_cycles < LONG_HOLD_CYCLES; held_cycles++)
          @(posedge clk);
        long_hold_req = 0;
        hold_active   = 0;
      end else if (steady_flow) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Sample each accepted output word, check once the input side has noted its word
  always @(posedge clk) begin
    logic [7:0] got_data;
    logic       got_last;
    logic       got_short;
    string      why;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got_data  = out_tdata;
      got_last  = out_tlast;
      got_short = out_tuser;
      #1;
      why = rewriter.match_output_word(got_data, got_last, got_short);
      if (why != "") report_mismatch(why);
    end
  end

  initial begin
    #2_000_000;
    $display("Run stopped by watchdog");
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    byte_q_t pkt;
    int i;
    rewriter    = new;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // spare index must be ignored; all-ones address
    cfg_write(REG_SPARE, 32'hdead_beef);
    cfg_write(REG_NAT_ADDRESS, 32'hffff_ffff);

    // largest header of all ones, then two payload words at the byte extremes
    pkt.delete();
    repeat (nsr_pkg::MAX_HEADER_BYTES) pkt.push_back(8'hff);
    pkt.push_back(8'h00);
    pkt.push_back(8'hff);
    send_bytes(pkt, 1'b1);

    // all-zero header, length raised to minimum, packet ends on the header
    pkt.delete();
    repeat (nsr_pkg::MIN_HEADER_BYTES) pkt.push_back(8'h00);
    send_bytes(pkt, 1'b1);

    // one-word packet flushed as short
    pkt.delete();
    pkt.push_back(8'h45);
    send_bytes(pkt, 1'b1);

    // short by a single word
    pkt.delete();
    pkt.push_back(8'h45);
    for (i = 1; i < nsr_pkg::MIN_HEADER_BYTES - 1; i++) pkt.push_back(8'($urandom_range(0, 255)));
    send_bytes(pkt, 1'b1);

    // address changes halfway through a header; the later value applies
    pkt.delete();
    pkt.push_back(8'h46);
    for (i = 1; i < 12; i++) pkt.push_back(8'($urandom_range(0, 255)));
    send_bytes(pkt, 1'b0);
    settle();
    cfg_write(REG_NAT_ADDRESS, 32'h0000_0000);
    pkt.delete();
    for (i = 0; i < 15; i++) pkt.push_back(8'($urandom_range(0, 255)));
    send_bytes(pkt, 1'b1);
    settle();

    // random traffic under several addresses, one phase under back-pressure
    run_random_phase($urandom(), 1'b0);
    run_random_phase(32'hffff_ffff, 1'b1);
    run_random_phase(32'h0000_0000, 1'b0);
    run_random_phase($urandom(), 1'b0);

    if (rewriter.expected_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived",
                                rewriter.expected_words.size()));

    $display("Sent %0d words in %0d packets: %0d headers rewritten, %0d short headers flushed.",
             rewriter.words_in, packets_sent, rewriter.full_headers, rewriter.short_flushes);
    $display("Checked %0d output words, including a %0d-cycle receiver hold-off.",
             rewriter.words_out, LONG_HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
